/* hw/rtl/lls_pkg.sv */
// Shared constants, types and helpers of the Laplacian level split block.
// Used by every module under hw/rtl except lls_ram; has no dependencies of its own.
package lls_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int SAMPLE_BITS = 16;

  localparam int CFG_W    = 12;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WSZ_W    = $clog2(MAX_WIDTH + 1);
  localparam int HSZ_W    = $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W    = (WSZ_W > HSZ_W) ? WSZ_W : HSZ_W;
  localparam int SIZE_W   = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int MEAN_W   = SAMPLE_BITS + 2;
  localparam int DETAIL_W = SAMPLE_BITS + 3;
  localparam int COORD_W  = 10;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2048);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    KIND_HOLD,
    KIND_EMIT
  } kind_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] tl;
    logic [SAMPLE_BITS-1:0] tr;
    logic [SAMPLE_BITS-1:0] bl;
    logic [SAMPLE_BITS-1:0] br;
    logic [COORD_W-1:0]     col;
    logic [COORD_W-1:0]     row;
    logic                   done;
  } blk_t;

  typedef struct packed {
    logic valid;
    blk_t blk;
  } q_push_t;

  function automatic logic [SIZE_W-1:0] effective_size(input logic [CFG_W-1:0] size_reg,
                                                       input int max_size);
    logic [SIZE_W-1:0] s;
    logic [SIZE_W-1:0] m;
    s = SIZE_W'({size_reg[CFG_W-1:1], 1'b0});
    m = SIZE_W'(max_size) & ~SIZE_W'(1);
    if (s < SIZE_W'(2)) s = SIZE_W'(2);
    if (s > m) s = m;
    return s;
  endfunction

endpackage

/* hw/rtl/lls_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module lls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/lls_front.sv */
// Front end: accepts samples, tracks raster position, keeps the even row in the
// row store and assembles complete 2x2 blocks. Depends on lls_pkg and lls_ram.
module lls_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lls_pkg::SAMPLE_BITS-1:0]     sample,
  input  logic [lls_pkg::CFG_W-1:0]           frame_width,
  input  logic [lls_pkg::CFG_W-1:0]           frame_height,
  input  logic [lls_pkg::QCNT_W-1:0]          q_count,
  output lls_pkg::q_push_t                    q_push
);

  logic [lls_pkg::SIZE_W-1:0]      eff_width;
  logic [lls_pkg::SIZE_W-1:0]      eff_height;
  logic [lls_pkg::COL_W-1:0]       column_count;
  logic [lls_pkg::ROW_W-1:0]       row_count;
  logic [lls_pkg::COL_W-1:0]       column_count_next;
  logic [lls_pkg::ROW_W-1:0]       row_count_next;
  logic [lls_pkg::SIZE_W-1:0]      col_inc;
  logic [lls_pkg::SIZE_W-1:0]      row_inc;
  logic                            col_wrap;
  logic                            row_wrap;
  logic                            accept;
  logic [lls_pkg::SAMPLE_BITS-1:0] store_q;

  logic                            b_valid;
  lls_pkg::kind_t                  b_kind;
  logic [lls_pkg::SAMPLE_BITS-1:0] b_px;
  logic [lls_pkg::COORD_W-1:0]     b_col;
  logic [lls_pkg::COORD_W-1:0]     b_row;
  logic                            b_done;
  logic                            b_push;
  logic [lls_pkg::SAMPLE_BITS-1:0] left_sample;
  logic [lls_pkg::SAMPLE_BITS-1:0] upper_left_hold;

  assign eff_width  = lls_pkg::effective_size(frame_width, lls_pkg::MAX_WIDTH);
  assign eff_height = lls_pkg::effective_size(frame_height, lls_pkg::MAX_HEIGHT);

  assign col_inc  = lls_pkg::SIZE_W'(column_count) + lls_pkg::SIZE_W'(1);
  assign row_inc  = lls_pkg::SIZE_W'(row_count) + lls_pkg::SIZE_W'(1);
  assign col_wrap = col_inc >= eff_width;
  assign row_wrap = row_inc >= eff_height;

  assign b_push   = b_valid && (b_kind == lls_pkg::KIND_EMIT);
  assign in_stall = ({1'b0, q_count} + (lls_pkg::QCNT_W + 1)'(b_push))
                    >= (lls_pkg::QCNT_W + 1)'(lls_pkg::QDEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    column_count_next = lls_pkg::COL_W'(col_inc);
    row_count_next    = row_count;
    if (col_wrap) begin
      column_count_next = '0;
      row_count_next    = row_wrap ? '0 : lls_pkg::ROW_W'(row_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  lls_ram #(
    .WIDTH(lls_pkg::SAMPLE_BITS),
    .DEPTH(lls_pkg::MAX_WIDTH)
  ) u_row_store (
    .clk  (clk),
    .we   (accept && !row_count[0]),
    .addr (column_count),
    .wdata(sample),
    .rdata(store_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept && row_count[0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_kind <= column_count[0] ? lls_pkg::KIND_EMIT : lls_pkg::KIND_HOLD;
      b_px   <= sample;
      b_col  <= lls_pkg::COORD_W'(column_count >> 1);
      b_row  <= lls_pkg::COORD_W'(row_count >> 1);
      b_done <= col_wrap && row_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sample     <= '0;
      upper_left_hold <= '0;
    end else if (b_valid && (b_kind == lls_pkg::KIND_HOLD)) begin
      left_sample     <= b_px;
      upper_left_hold <= store_q;
    end
  end

  always_comb begin
    q_push.valid    = b_push;
    q_push.blk.tl   = upper_left_hold;
    q_push.blk.tr   = store_q;
    q_push.blk.bl   = left_sample;
    q_push.blk.br   = b_px;
    q_push.blk.col  = b_col;
    q_push.blk.row  = b_row;
    q_push.blk.done = b_done;
  end

endmodule

/* hw/rtl/lls_queue.sv */
// Short block queue between front end and back end.
// Depends on lls_pkg.
module lls_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  lls_pkg::q_push_t           push,
  input  logic                       pop,
  output logic                       head_valid,
  output lls_pkg::blk_t              head,
  output logic [lls_pkg::QCNT_W-1:0] count
);

  lls_pkg::blk_t               slots [lls_pkg::QDEPTH];
  logic [lls_pkg::QPTR_W-1:0]  wr_ptr;
  logic [lls_pkg::QPTR_W-1:0]  rd_ptr;
  logic [lls_pkg::QPTR_W-1:0]  wr_ptr_next;
  logic [lls_pkg::QPTR_W-1:0]  rd_ptr_next;

  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  assign wr_ptr_next = (wr_ptr == lls_pkg::QPTR_W'(lls_pkg::QDEPTH - 1)) ? '0
                       : wr_ptr + lls_pkg::QPTR_W'(1);
  assign rd_ptr_next = (rd_ptr == lls_pkg::QPTR_W'(lls_pkg::QDEPTH - 1)) ? '0
                       : rd_ptr + lls_pkg::QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (push.valid && !pop) begin
        count <= count + lls_pkg::QCNT_W'(1);
      end else if (pop && !push.valid) begin
        count <= count - lls_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.blk;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lls_pkg::QCNT_W'(lls_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && !pop && (count == lls_pkg::QCNT_W'(lls_pkg::QDEPTH))))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && (count == '0)))
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop) |=> (count == $past(count) + lls_pkg::QCNT_W'(1)))
    else $error("queue count lost a push");

endmodule

/* hw/rtl/lls_back.sv */
// Back end: forms block sum and detail values and holds them in the output
// register. Depends on lls_pkg.
module lls_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  lls_pkg::blk_t                        head,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lls_pkg::MEAN_W-1:0]           mean_quarters,
  output logic signed [lls_pkg::DETAIL_W-1:0]  detail_top_left,
  output logic signed [lls_pkg::DETAIL_W-1:0]  detail_top_right,
  output logic signed [lls_pkg::DETAIL_W-1:0]  detail_bottom_left,
  output logic signed [lls_pkg::DETAIL_W-1:0]  detail_bottom_right,
  output logic [lls_pkg::COORD_W-1:0]          block_column,
  output logic [lls_pkg::COORD_W-1:0]          block_row,
  output logic                                 frame_done
);

  logic                          load;
  logic [lls_pkg::MEAN_W-1:0]    sum;
  logic [lls_pkg::DETAIL_W-1:0]  sum_x;

  function automatic logic [lls_pkg::DETAIL_W-1:0] detail(
      input logic [lls_pkg::SAMPLE_BITS-1:0] px,
      input logic [lls_pkg::DETAIL_W-1:0]    total);
    logic [lls_pkg::DETAIL_W-1:0] px4;
    px4 = lls_pkg::DETAIL_W'({px, 2'b00});
    return px4 - total;
  endfunction

  assign load = !out_valid || !out_stall;
  assign pop  = head_valid && load;

  assign sum = lls_pkg::MEAN_W'(head.tl) + lls_pkg::MEAN_W'(head.tr)
             + lls_pkg::MEAN_W'(head.bl) + lls_pkg::MEAN_W'(head.br);
  assign sum_x = lls_pkg::DETAIL_W'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mean_quarters       <= sum;
      detail_top_left     <= detail(head.tl, sum_x);
      detail_top_right    <= detail(head.tr, sum_x);
      detail_bottom_left  <= detail(head.bl, sum_x);
      detail_bottom_right <= detail(head.br, sum_x);
      block_column        <= head.col;
      block_row           <= head.row;
      frame_done          <= head.done;
    end
  end

endmodule

/* hw/rtl/laplacian_level_split_top.sv */
// Laplacian level split: one sample per clock in while in_stall is low, one 2x2
// block result per completed block out via the front end block register, a queue
// slot and output register. Rate set by the single-port row store access per pixel.
// Reset (synchronous) clears counters, queue and output valid and sets both sizes
// to 2048; the row store is not cleared and needs no clearing pass.
// Depends on lls_pkg, lls_front, lls_queue, lls_back.
module laplacian_level_split_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lls_pkg::PADDR_W-1:0]          paddr,
  input  logic [lls_pkg::PDATA_W-1:0]          pwdata,
  output logic [lls_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lls_pkg::SAMPLE_BITS-1:0]      sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lls_pkg::MEAN_W-1:0]           mean_quarters,
  output logic signed [lls_pkg::DETAIL_W-1:0]  detail_top_left,
  output logic signed [lls_pkg::DETAIL_W-1:0]  detail_top_right,
  output logic signed [lls_pkg::DETAIL_W-1:0]  detail_bottom_left,
  output logic signed [lls_pkg::DETAIL_W-1:0]  detail_bottom_right,
  output logic [lls_pkg::COORD_W-1:0]          block_column,
  output logic [lls_pkg::COORD_W-1:0]          block_row,
  output logic                                 frame_done
);

  logic [lls_pkg::CFG_W-1:0]  frame_width;
  logic [lls_pkg::CFG_W-1:0]  frame_height;
  lls_pkg::reg_idx_t          reg_sel;
  logic                       cfg_write;
  lls_pkg::q_push_t           q_push;
  logic                       q_pop;
  logic                       q_valid;
  lls_pkg::blk_t              q_head;
  logic [lls_pkg::QCNT_W-1:0] q_count;

  assign pready    = 1'b1;
  assign reg_sel   = lls_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lls_pkg::CFG_RESET;
      frame_height <= lls_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        lls_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[lls_pkg::CFG_W-1:0];
        lls_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[lls_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lls_pkg::REG_FRAME_WIDTH:  prdata = lls_pkg::PDATA_W'(frame_width);
      lls_pkg::REG_FRAME_HEIGHT: prdata = lls_pkg::PDATA_W'(frame_height);
      default:                   prdata = '0;
    endcase
  end

  lls_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .q_count     (q_count),
    .q_push      (q_push)
  );

  lls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head),
    .count     (q_count)
  );

  lls_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head_valid         (q_valid),
    .head               (q_head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .mean_quarters      (mean_quarters),
    .detail_top_left    (detail_top_left),
    .detail_top_right   (detail_top_right),
    .detail_bottom_left (detail_bottom_left),
    .detail_bottom_right(detail_bottom_right),
    .block_column       (block_column),
    .block_row          (block_row),
    .frame_done         (frame_done)
  );

endmodule
